/* design/ttc_pkg.sv */
package ttc_pkg;

  localparam int ADC_BITS       = 10;
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_TAB_SIZE   = 1 << LOG_TABLE_BITS;
  localparam int OHM_W          = 20;
  localparam int BETA_W         = 16;
  localparam int PROD_W         = OHM_W + ADC_BITS;
  localparam int POS_W          = $clog2(PROD_W);
  localparam int FRAC_W         = 16;
  localparam int LOG_W          = POS_W + FRAC_W;
  localparam int D_W            = LOG_W + 2;
  localparam int MAG_W          = LOG_W + 1;
  localparam int LN2_W          = 32;
  localparam int MUL_W          = MAG_W + LN2_W;
  localparam int DIV_W          = 40;
  localparam int DIVISOR_W      = 16;
  localparam int Q_W            = 17;
  localparam int INV_W          = DIV_W + 2;
  localparam int TEMP_W         = 16;
  localparam int CFG_W          = 20;

  localparam logic [LN2_W-1:0]   LN2_Q32        = 32'd2977044472;
  localparam logic [DIV_W-1:0]   HUNDRED_Q32    = 40'd429496729600;
  localparam logic [ADC_BITS:0]  ADC_FULL       = (ADC_BITS + 1)'(1 << ADC_BITS);
  localparam int                 KELVIN_OFS_CK  = 27315;
  localparam int                 TEMP_MAX       = 32767;

  typedef enum logic [2:0] {
    REG_MOTOR_SERIES   = 3'd0,
    REG_MOTOR_NOMINAL  = 3'd1,
    REG_MOTOR_BETA     = 3'd2,
    REG_REG_SERIES     = 3'd3,
    REG_REG_NOMINAL    = 3'd4,
    REG_REG_BETA       = 3'd5,
    REG_NOMINAL_TEMP   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic flag;
  } div_tag_t;

  typedef logic [FRAC_W-1:0] log_tab_t [LOG_TAB_SIZE];

  // log2(1 + i/2^L) in Q0.16 by repeated squaring of a Q1.30 mantissa
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] m;
    logic [15:0] r;
    for (int i = 0; i < LOG_TAB_SIZE; i++) begin
      m = 64'(LOG_TAB_SIZE + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        r = {r[14:0], 1'b0};
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          r[0] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

/* design/ttc_log2.sv */
module ttc_log2 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ttc_pkg::PROD_W-1:0]    x,
  output logic [ttc_pkg::LOG_W-1:0]     y
);

  logic [ttc_pkg::POS_W-1:0]  pos_c;
  logic [ttc_pkg::POS_W-1:0]  pos;
  logic [ttc_pkg::PROD_W-1:0] xr;
  logic [ttc_pkg::PROD_W-1:0] xn;
  logic [ttc_pkg::LOG_TABLE_BITS-1:0] idx;

  // leading-one index; zero input reads as index 0
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < ttc_pkg::PROD_W; i++) begin
      if (x[i]) pos_c = ttc_pkg::POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= pos_c;
      xr  <= x;
    end
  end

  assign xn  = xr << (ttc_pkg::POS_W'(ttc_pkg::PROD_W - 1) - pos);
  assign idx = xn[ttc_pkg::PROD_W-2 -: ttc_pkg::LOG_TABLE_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      y <= {pos, ttc_pkg::LOG_TAB[idx]};
    end
  end

endmodule

/* design/ttc_div_pipe.sv */
module ttc_div_pipe (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [ttc_pkg::DIV_W-1:0]       num,
  input  logic [ttc_pkg::DIVISOR_W-1:0]   den,
  input  ttc_pkg::div_tag_t               tag_in,
  output logic [ttc_pkg::DIV_W-1:0]       quo,
  output ttc_pkg::div_tag_t               tag_out
);

  localparam int N = ttc_pkg::DIV_W;

  // one quotient bit per stage; wq shifts the dividend out and the quotient in
  logic [ttc_pkg::DIVISOR_W-1:0] rem [N+1];
  logic [N-1:0]                  wq  [N+1];
  logic [ttc_pkg::DIVISOR_W-1:0] dv  [N+1];
  logic                          vl  [N+1];
  logic                          fl  [N+1];

  assign rem[0] = '0;
  assign wq[0]  = num;
  assign dv[0]  = den;
  assign vl[0]  = tag_in.valid;
  assign fl[0]  = tag_in.flag;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [ttc_pkg::DIVISOR_W:0] trial;
    logic                        ge;
    assign trial = {rem[s], wq[s][N-1]};
    assign ge    = trial >= {1'b0, dv[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? ttc_pkg::DIVISOR_W'(trial - {1'b0, dv[s]})
                       : ttc_pkg::DIVISOR_W'(trial);
        wq[s+1]  <= {wq[s][N-2:0], ge};
        dv[s+1]  <= dv[s];
        fl[s+1]  <= fl[s];
      end
    end
  end

  assign quo           = wq[N];
  assign tag_out.valid = vl[N];
  assign tag_out.flag  = fl[N];

endmodule

/* design/ttc_recip_pipe.sv */
module ttc_recip_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [ttc_pkg::DIV_W-1:0]      inv,
  input  logic                           zero_in,
  input  logic                           nonpos_in,
  output logic                           out_valid,
  output logic [ttc_pkg::TEMP_W-1:0]     temp,
  output logic [1:0]                     status
);

  localparam int N = ttc_pkg::Q_W;
  localparam int W = ttc_pkg::DIV_W;

  logic [W-1:0] m_c;
  logic         ovf_c;

  // T in centikelvin = round(100*2^32 / inv); results above 2^Q_W saturate anyway
  assign m_c   = ttc_pkg::HUNDRED_Q32 + (inv >> 1);
  assign ovf_c = {{N{1'b0}}, m_c} >= {inv, {N{1'b0}}};

  logic [W-1:0] rem [N+1];
  logic [N-1:0] wq  [N+1];
  logic [W-1:0] dv  [N+1];
  logic         vl  [N+1];
  logic         zr  [N+1];
  logic         sat [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(m_c >> N);
      wq[0]  <= m_c[N-1:0];
      dv[0]  <= inv;
      zr[0]  <= zero_in;
      sat[0] <= nonpos_in | ovf_c;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem[s], wq[s][N-1]};
    assign ge    = trial >= {1'b0, dv[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? W'(trial - {1'b0, dv[s]}) : W'(trial);
        wq[s+1]  <= {wq[s][N-2:0], ge};
        dv[s+1]  <= dv[s];
        zr[s+1]  <= zr[s];
        sat[s+1] <= sat[s];
      end
    end
  end

  logic signed [N+1:0]              t_c;
  logic [ttc_pkg::TEMP_W-1:0]       temp_next;
  logic [1:0]                       status_next;

  assign t_c = $signed({2'b0, wq[N]}) - (N+2)'(ttc_pkg::KELVIN_OFS_CK);

  always_comb begin
    priority if (zr[N]) begin
      temp_next   = ttc_pkg::TEMP_W'(-ttc_pkg::KELVIN_OFS_CK);
      status_next = ttc_pkg::STAT_ZERO;
    end else if (sat[N] || t_c > (N+2)'(ttc_pkg::TEMP_MAX)) begin
      temp_next   = ttc_pkg::TEMP_W'(ttc_pkg::TEMP_MAX);
      status_next = ttc_pkg::STAT_SAT;
    end else begin
      temp_next   = t_c[ttc_pkg::TEMP_W-1:0];
      status_next = ttc_pkg::STAT_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp   <= temp_next;
      status <= status_next;
    end
  end

endmodule

/* design/thermistor_adc_to_temperature.sv */
// channel  | group                    | contents (low bit first)
// input    | s_tvalid/s_tready        | s_tdata: adc_code[9:0]; s_tuser: sensor_kind
// output   | m_tvalid/m_tready        | m_tdata: temp_centidegrees; m_tuser: status
// config   | wr_en/wr_index/wr_data   | register index 0..6, value
// One request per cycle while the output is not stalled; the depth is set by the two 40-bit
// quotient dividers (beta scaling and 1/T0) and the 17-bit reciprocal.
// Synchronous reset clears valid bits and loads register defaults.
// A stall on the output freezes every stage; s_tready follows it directly.
module thermistor_adc_to_temperature (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // adc_code[9:0], zero pad
  input  logic                         s_tuser,   // sensor_kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata,   // temp_centidegrees
  output logic [1:0]                   m_tuser,   // status
  input  logic                         wr_en,
  input  logic [2:0]                   wr_index,
  input  logic [ttc_pkg::CFG_W-1:0]    wr_data
);

  logic [ttc_pkg::OHM_W-1:0]  motor_series, motor_nominal, reg_series, reg_nominal;
  logic [ttc_pkg::BETA_W-1:0] motor_beta, reg_beta, nominal_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_series  <= 20'd10000;
      motor_nominal <= 20'd7931;
      motor_beta    <= 16'd3950;
      reg_series    <= 20'd10000;
      reg_nominal   <= 20'd2760;
      reg_beta      <= 16'd3950;
      nominal_temp  <= 16'd33315;
    end else if (wr_en) begin
      unique case (wr_index)
        ttc_pkg::REG_MOTOR_SERIES:  motor_series  <= wr_data;
        ttc_pkg::REG_MOTOR_NOMINAL: motor_nominal <= wr_data;
        ttc_pkg::REG_MOTOR_BETA:    motor_beta    <= wr_data[ttc_pkg::BETA_W-1:0];
        ttc_pkg::REG_REG_SERIES:    reg_series    <= wr_data;
        ttc_pkg::REG_REG_NOMINAL:   reg_nominal   <= wr_data;
        ttc_pkg::REG_REG_BETA:      reg_beta      <= wr_data[ttc_pkg::BETA_W-1:0];
        ttc_pkg::REG_NOMINAL_TEMP:  nominal_temp  <= wr_data[ttc_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: pick register set, zero registers read as one
  logic [ttc_pkg::ADC_BITS-1:0] code_c;
  logic [ttc_pkg::OHM_W-1:0]    ser_c, nom_c;
  logic [ttc_pkg::BETA_W-1:0]   beta_c, t0_c;
  assign code_c = s_tdata[ttc_pkg::ADC_BITS-1:0];
  assign ser_c  = s_tuser ? reg_series  : motor_series;
  assign nom_c  = s_tuser ? reg_nominal : motor_nominal;
  assign beta_c = s_tuser ? reg_beta    : motor_beta;
  assign t0_c   = nominal_temp;

  logic                         v1, v2, v3, v4, v5, v6, v7;
  logic [ttc_pkg::ADC_BITS-1:0] code1;
  logic [ttc_pkg::ADC_BITS:0]   diff1, diff2;
  logic [ttc_pkg::OHM_W-1:0]    ser1, nom1, nom2;
  logic [ttc_pkg::BETA_W-1:0]   beta1, beta2, beta3, beta4, beta5, beta6, beta7;
  logic [ttc_pkg::BETA_W-1:0]   t01, t02, t03, t04, t05, t06, t07;
  logic                         z1, z2, z3, z4, z5, z6, z7;
  logic [ttc_pkg::PROD_W-1:0]   prod2;
  logic                         neg5, neg6, neg7;
  logic [ttc_pkg::MAG_W-1:0]    mag5;
  logic [ttc_pkg::MUL_W-1:0]    mul6;
  logic [ttc_pkg::DIV_W-1:0]    xa7, xb7;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7} <= {s_tvalid, v1, v2, v3, v4, v5, v6};
    end
  end

  logic [ttc_pkg::LOG_W-1:0] la, lb, lc;
  logic signed [ttc_pkg::D_W-1:0] d_c;
  logic [ttc_pkg::MUL_W-1:0] xa_sum;

  assign d_c = $signed({2'b0, la}) - $signed({2'b0, lb}) - $signed({2'b0, lc});
  assign xa_sum = mul6 + (ttc_pkg::MUL_W'(beta6) << 15);

  always_ff @(posedge clk) begin
    if (en) begin
      code1 <= code_c;
      diff1 <= ttc_pkg::ADC_FULL - {1'b0, code_c};
      ser1  <= (ser_c  == '0) ? ttc_pkg::OHM_W'(1)  : ser_c;
      nom1  <= (nom_c  == '0) ? ttc_pkg::OHM_W'(1)  : nom_c;
      beta1 <= (beta_c == '0) ? ttc_pkg::BETA_W'(1) : beta_c;
      t01   <= (t0_c   == '0) ? ttc_pkg::BETA_W'(1) : t0_c;
      z1    <= code_c == '0;

      prod2 <= ser1 * code1;
      diff2 <= diff1;
      nom2  <= nom1;
      beta2 <= beta1;
      t02   <= t01;
      z2    <= z1;

      {beta3, t03, z3} <= {beta2, t02, z2};
      {beta4, t04, z4} <= {beta3, t03, z3};

      // log2(R/R0) in Q.16
      neg5  <= d_c[ttc_pkg::D_W-1];
      mag5  <= d_c[ttc_pkg::D_W-1] ? ttc_pkg::MAG_W'(-d_c) : ttc_pkg::MAG_W'(d_c);
      {beta5, t05, z5} <= {beta4, t04, z4};

      mul6  <= mag5 * ttc_pkg::LN2_Q32;
      {neg6, beta6, t06, z6} <= {neg5, beta5, t05, z5};

      // dividing by beta*2^16 with rounding: pre-shift, then divide by beta
      xa7   <= ttc_pkg::DIV_W'(xa_sum >> 16);
      xb7   <= ttc_pkg::HUNDRED_Q32 + ttc_pkg::DIV_W'(t06 >> 1);
      {neg7, beta7, t07, z7} <= {neg6, beta6, t06, z6};
    end
  end

  ttc_log2 u_log_a (.clk(clk), .en(en), .x(prod2), .y(la));
  ttc_log2 u_log_b (.clk(clk), .en(en), .x(ttc_pkg::PROD_W'(diff2)), .y(lb));
  ttc_log2 u_log_c (.clk(clk), .en(en), .x(ttc_pkg::PROD_W'(nom2)), .y(lc));

  logic [ttc_pkg::DIV_W-1:0] term, inv0;
  ttc_pkg::div_tag_t tag_a, tag_b;

  ttc_div_pipe u_div_term (
    .clk(clk), .rst(rst), .en(en),
    .num(xa7), .den(beta7),
    .tag_in('{valid: v7, flag: neg7}),
    .quo(term), .tag_out(tag_a)
  );

  ttc_div_pipe u_div_inv0 (
    .clk(clk), .rst(rst), .en(en),
    .num(xb7), .den(t07),
    .tag_in('{valid: v7, flag: z7}),
    .quo(inv0), .tag_out(tag_b)
  );

  logic signed [ttc_pkg::INV_W-1:0] inv_c;
  logic                             v8, z8, np8;
  logic [ttc_pkg::DIV_W-1:0]        inv8;

  assign inv_c = tag_a.flag ? $signed({2'b0, inv0}) - $signed({2'b0, term})
                            : $signed({2'b0, inv0}) + $signed({2'b0, term});

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= tag_a.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv8 <= inv_c[ttc_pkg::DIV_W-1:0];
      z8   <= tag_b.flag;
      np8  <= inv_c <= 0;
    end
  end

  ttc_recip_pipe u_recip (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v8), .inv(inv8), .zero_in(z8), .nonpos_in(np8),
    .out_valid(m_tvalid), .temp(m_tdata), .status(m_tuser)
  );

endmodule
